### rtl/sacl_pkg.sv
`default_nettype none

package sacl_pkg;

	localparam int ADDR_W      = 32;
	localparam int OFFSET_W    = 5;
	localparam int TOTAL_LINES = 512;
	localparam int MAX_WAYS    = 16;
	localparam int LINE_IDX_W  = $clog2(TOTAL_LINES);
	localparam int WAY_W       = $clog2(MAX_WAYS);
	localparam int ROWS        = TOTAL_LINES / MAX_WAYS;
	localparam int ROW_W       = $clog2(ROWS);
	localparam int TAG_W       = ADDR_W - OFFSET_W - ROW_W;
	localparam int RANK_W      = 4;
	localparam int LG_W        = 3;
	localparam int LG_MIN      = 1;
	localparam int LG_MAX      = $clog2(MAX_WAYS);
	localparam int CNT_W       = 32;

	// one line of the tag store
	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic              valid;
		logic [RANK_W-1:0] rank;
	} lane_t;

	// one RAM row: every line of the widest set
	typedef lane_t [MAX_WAYS-1:0] row_t;

	localparam int ROW_BITS = $bits(row_t);

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic look;
		logic update;
	} cmd_t;

endpackage

`default_nettype wire

### rtl/set_assoc_cache_lru_tags.sv
// Tag store of a 16 KiB set-associative cache with 32-byte lines and LRU
// replacement. Pulse start with an address while busy is low; after lookup
// and write-back the result (hit, way_used, hit_total) shows for exactly
// one cycle with done high, and it cannot be held off, so capture it then.
// A new item may start in a write-back cycle: each access needs one read
// and one write-back of its set on the single-port-pair tag RAM. Busy is
// high only in the lookup cycle. The way count (cfg_data = log2 of ways,
// 1..4) is written through the config channel while idle; cfg_ready is low
// while an item is in its lookup or write-back cycle. The write empties the
// store at once, with no clearing pass, and the hit count is kept.
`default_nettype none

module set_assoc_cache_lru_tags
	import sacl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [ADDR_W-1:0] address,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [LG_W-1:0]   cfg_data,
	output logic                   done,
	output logic                   hit,
	output logic [WAY_W-1:0]       way_used,
	output logic [CNT_W-1:0]       hit_total
);

	cmd_t cmd;

	// take a way-count write only when no item is in flight
	assign cfg_ready = !(cmd.look || cmd.update);

	// sequence the lookup and write-back cycles
	sacl_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd)
	);

	// hold tags, ranks and the hit count
	sacl_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.address  (address),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.done     (done),
		.hit      (hit),
		.way_used (way_used),
		.hit_total(hit_total)
	);

	// an accepted item always moves into the lookup cycle
	a_accept_look: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not enter lookup");

	// lookup lasts one cycle
	a_look_once: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("lookup held for more than one cycle");

	// a hit advances the count by one unless saturated
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> ((hit_total == $past(hit_total) + 1'b1) || (hit_total == '1)))
		else $error("hit did not advance the hit count");

	// a miss leaves the count alone
	a_miss_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (hit_total == $past(hit_total)))
		else $error("miss changed the hit count");

endmodule

`default_nettype wire

### rtl/sacl_ram.sv
`default_nettype none

module sacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/sacl_ctrl.sv
`default_nettype none

module sacl_ctrl
	import sacl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_LOOK   = 3'b010,
		ST_UPDATE = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign busy   = (state_q == ST_LOOK);
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept) state_d = ST_LOOK;
			ST_LOOK:   state_d = ST_UPDATE;
			ST_UPDATE: state_d = accept ? ST_LOOK : ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.accept = accept;
	assign cmd.look   = (state_q == ST_LOOK);
	assign cmd.update = (state_q == ST_UPDATE);

endmodule

`default_nettype wire

### rtl/sacl_dp.sv
`default_nettype none

module sacl_dp
	import sacl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	input  wire logic [ADDR_W-1:0] address,
	input  wire logic              cfg_we,
	input  wire logic [LG_W-1:0]   cfg_data,
	output logic                   done,
	output logic                   hit,
	output logic [WAY_W-1:0]       way_used,
	output logic [CNT_W-1:0]       hit_total
);

	typedef struct packed {
		logic              elig;
		logic [RANK_W-1:0] rank;
		logic [WAY_W-1:0]  lane;
	} node_t;

	localparam int NODES = 2 * MAX_WAYS - 1;

	logic [LG_W-1:0]       ways_q;
	logic [LG_W-1:0]       lg;
	logic [WAY_W-1:0]      way_mask;
	logic [ROWS-1:0]       row_valid_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  fwd_q;
	logic                  done_q;
	logic                  hit_q;
	logic [WAY_W-1:0]      way_q;
	logic [ADDR_W-1:0]     addr_q;
	row_t                  row_s2;
	logic                  hit_s2;
	logic [WAY_W-1:0]      lane_s2;

	logic [LINE_IDX_W-1:0] in_base;
	logic [LINE_IDX_W-1:0] cur_base;
	logic [ROW_W-1:0]      in_row;
	logic [ROW_W-1:0]      cur_row;
	logic [WAY_W-1:0]      cur_lane0;
	logic [TAG_W-1:0]      cur_tag;
	logic [MAX_WAYS-1:0]   in_set;

	row_t                  ram_rdata;
	row_t                  row_rd;
	row_t                  row_new;
	logic [MAX_WAYS-1:0]   match;
	logic [MAX_WAYS-1:0]   empty;
	logic                  any_match;
	logic                  any_empty;
	logic [WAY_W-1:0]      match_lane;
	logic [WAY_W-1:0]      empty_lane;
	logic [WAY_W-1:0]      chosen;
	node_t                 tree [NODES];
	lane_t                 cl;
	logic [RANK_W:0]       old_rank;

	// clamp the way count to the legal range
	always_comb begin
		if (ways_q < LG_W'(LG_MIN)) begin
			lg = LG_W'(LG_MIN);
		end else if (ways_q > LG_W'(LG_MAX)) begin
			lg = LG_W'(LG_MAX);
		end else begin
			lg = ways_q;
		end
	end

	assign way_mask  = WAY_W'((1 << lg) - 1);

	// sets are aligned to the way count, so a set never crosses a row
	assign in_base   = LINE_IDX_W'(address[OFFSET_W +: LINE_IDX_W] << lg);
	assign cur_base  = LINE_IDX_W'(addr_q[OFFSET_W +: LINE_IDX_W] << lg);
	assign in_row    = in_base[LINE_IDX_W-1 -: ROW_W];
	assign cur_row   = cur_base[LINE_IDX_W-1 -: ROW_W];
	assign cur_lane0 = cur_base[WAY_W-1:0];
	assign cur_tag   = TAG_W'(addr_q >> (OFFSET_W + LINE_IDX_W - int'(lg)));

	always_comb begin
		for (int l = 0; l < MAX_WAYS; l++) begin
			in_set[l] = ((WAY_W'(l) & ~way_mask) == cur_lane0);
		end
	end

	sacl_ram #(
		.WIDTH(ROW_BITS),
		.DEPTH(ROWS)
	) u_ram (
		.clk  (clk),
		.we   (cmd.update),
		.waddr(cur_row),
		.wdata(row_new),
		.raddr(in_row),
		.rdata(ram_rdata)
	);

	// row seen by the lookup: forwarded write-back, RAM data, or empty
	always_comb begin
		if (fwd_q) begin
			row_rd = row_s2;
		end else if (row_valid_q[cur_row]) begin
			row_rd = ram_rdata;
		end else begin
			row_rd = '0;
		end
	end

	always_comb begin
		for (int l = 0; l < MAX_WAYS; l++) begin
			match[l] = in_set[l] && row_rd[l].valid && (row_rd[l].tag == cur_tag);
			empty[l] = in_set[l] && !row_rd[l].valid;
		end
		any_match  = |match;
		any_empty  = |empty;
		match_lane = '0;
		empty_lane = '0;
		for (int l = MAX_WAYS - 1; l >= 0; l--) begin
			if (match[l]) match_lane = WAY_W'(l);
			if (empty[l]) empty_lane = WAY_W'(l);
		end
	end

	// oldest-line tree; ties go to the lower lane
	always_comb begin
		for (int l = 0; l < MAX_WAYS; l++) begin
			tree[MAX_WAYS-1+l].elig = in_set[l];
			tree[MAX_WAYS-1+l].rank = row_rd[l].rank;
			tree[MAX_WAYS-1+l].lane = WAY_W'(l);
		end
		for (int i = MAX_WAYS - 2; i >= 0; i--) begin
			if (tree[2*i+1].elig && (!tree[2*i+2].elig ||
					tree[2*i+1].rank >= tree[2*i+2].rank)) begin
				tree[i] = tree[2*i+1];
			end else begin
				tree[i] = tree[2*i+2];
			end
		end
	end

	always_comb begin
		if (any_match) begin
			chosen = match_lane;
		end else if (any_empty) begin
			chosen = empty_lane;
		end else begin
			chosen = tree[0].lane;
		end
	end

	// write-back row: age the younger lines, refresh the chosen one
	always_comb begin
		cl       = row_s2[lane_s2];
		old_rank = cl.valid ? {1'b0, cl.rank} : {1'b1, {RANK_W{1'b0}}};
		for (int l = 0; l < MAX_WAYS; l++) begin
			row_new[l] = row_s2[l];
			if (WAY_W'(l) == lane_s2) begin
				row_new[l].tag   = cur_tag;
				row_new[l].valid = 1'b1;
				row_new[l].rank  = '0;
			end else if (in_set[l] && row_s2[l].valid &&
					({1'b0, row_s2[l].rank} < old_rank) && (row_s2[l].rank != '1)) begin
				row_new[l].rank = row_s2[l].rank + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_q      <= LG_W'(LG_MIN);
			row_valid_q <= '0;
			cnt_q       <= '0;
			fwd_q       <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.update;
			if (cfg_we) begin
				ways_q      <= cfg_data;
				row_valid_q <= '0;
			end else if (cmd.update) begin
				row_valid_q[cur_row] <= 1'b1;
			end
			if (cmd.update && hit_s2 && (cnt_q != '1)) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.accept) begin
				fwd_q <= cmd.update && (in_row == cur_row);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q <= address;
		end
		if (cmd.look) begin
			row_s2  <= row_rd;
			hit_s2  <= any_match;
			lane_s2 <= chosen;
		end else if (cmd.update) begin
			row_s2 <= row_new;
		end
		if (cmd.update) begin
			hit_q <= hit_s2;
			way_q <= lane_s2 & way_mask;
		end
	end

	assign done      = done_q;
	assign hit       = hit_q;
	assign way_used  = way_q;
	assign hit_total = cnt_q;

endmodule

`default_nettype wire

### tb/tb_set_assoc_cache_lru_tags.sv
// Scoreboard for the LRU tag store: keeps its own copy of the tags, valid bits,
// ages and hit count, works out the result of every accepted access and
// compares the results that come back in order.
class lru_tag_tracker;
	typedef struct packed {
		logic             hit;
		logic [sacl_pkg::WAY_W-1:0] way;
		logic [sacl_pkg::CNT_W-1:0] total;
	} access_result_t;

	logic [sacl_pkg::ADDR_W-1:0] line_tag [sacl_pkg::TOTAL_LINES];
	bit                          line_valid [sacl_pkg::TOTAL_LINES];
	int                          line_age [sacl_pkg::TOTAL_LINES];
	logic [sacl_pkg::CNT_W-1:0]  hit_count;
	logic [sacl_pkg::LG_W-1:0]   ways_lg;
	access_result_t              awaited_results [$];
	int errors;
	int compared;
	int hits_seen;

	function new();
		ways_lg = sacl_pkg::LG_MIN;
		hit_count = '0;
		errors = 0;
		compared = 0;
		hits_seen = 0;
		empty_store();
	endfunction

	function void empty_store();
		foreach (line_valid[i]) begin
			line_valid[i] = 1'b0;
			line_age[i] = 0;
		end
	endfunction

	// out-of-range settings clamp to the nearest legal way count
	function int way_total();
		int lg;
		lg = ways_lg;
		if (lg < sacl_pkg::LG_MIN) lg = sacl_pkg::LG_MIN;
		if (lg > sacl_pkg::LG_MAX) lg = sacl_pkg::LG_MAX;
		return 1 << lg;
	endfunction

	function int set_bits();
		return $clog2(sacl_pkg::TOTAL_LINES / way_total());
	endfunction

	function void configure(logic [sacl_pkg::LG_W-1:0] lg);
		ways_lg = lg;
		empty_store();
	endfunction

	function access_result_t lookup_and_fill(logic [sacl_pkg::ADDR_W-1:0] addr);
		int ways;
		int sets;
		int base;
		int chosen;
		int oldest;
		int old_age;
		int ln;
		bit is_hit;
		bit found;
		logic [sacl_pkg::ADDR_W-1:0] tag;
		logic [sacl_pkg::ADDR_W-1:0] set_no;
		access_result_t r;
		ways = way_total();
		sets = sacl_pkg::TOTAL_LINES / ways;
		set_no = (addr >> sacl_pkg::OFFSET_W) & (sets - 1);
		tag = addr >> (sacl_pkg::OFFSET_W + set_bits());
		base = int'(set_no) * ways;
		is_hit = 1'b0;
		found = 1'b0;
		chosen = 0;
		for (int w = 0; w < ways; w++) begin
			if (!is_hit && line_valid[base + w] && line_tag[base + w] == tag) begin
				is_hit = 1'b1;
				chosen = w;
			end
		end
		if (is_hit) begin
			if (hit_count != '1) hit_count++;
		end else begin
			// fill the lowest empty way, else evict the oldest (lowest way on a tie)
			for (int w = 0; w < ways; w++) begin
				if (!found && !line_valid[base + w]) begin
					chosen = w;
					found = 1'b1;
				end
			end
			if (!found) begin
				oldest = -1;
				for (int w = 0; w < ways; w++) begin
					if (line_age[base + w] > oldest) begin
						oldest = line_age[base + w];
						chosen = w;
					end
				end
			end
		end
		ln = base + chosen;
		old_age = line_valid[ln] ? line_age[ln] : 16;
		// age every valid line younger than the one being touched
		for (int w = 0; w < ways; w++) begin
			if (w != chosen && line_valid[base + w] && line_age[base + w] < old_age
				&& line_age[base + w] < 15)
				line_age[base + w]++;
		end
		line_tag[ln] = tag;
		line_valid[ln] = 1'b1;
		line_age[ln] = 0;
		r.hit = is_hit;
		r.way = chosen[sacl_pkg::WAY_W-1:0];
		r.total = hit_count;
		return r;
	endfunction

	function void note_access(logic [sacl_pkg::ADDR_W-1:0] addr);
		awaited_results.insert(awaited_results.size(), lookup_and_fill(addr));
	endfunction

	function void flag(string msg);
		errors++;
		if (errors <= 10) $display("mismatch: %s", msg);
	endfunction

	function void check_result(logic h, logic [sacl_pkg::WAY_W-1:0] w,
			logic [sacl_pkg::CNT_W-1:0] t);
		access_result_t e;
		if (h) hits_seen++;
		if (awaited_results.size() == 0) begin
			flag($sformatf("result with no access pending (hit %0d way %0d total %0d)",
				h, w, t));
			return;
		end
		e = awaited_results.pop_front();
		compared++;
		if (h !== e.hit)
			flag($sformatf("hit expected %0d got %0d", e.hit, h));
		if (w !== e.way)
			flag($sformatf("way_used expected %0d got %0d", e.way, w));
		if (t !== e.total)
			flag($sformatf("hit_total expected %0d got %0d", e.total, t));
	endfunction

	function int outstanding();
		return awaited_results.size();
	endfunction
endclass

module tb_set_assoc_cache_lru_tags;
	import sacl_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [ADDR_W-1:0] address;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [LG_W-1:0]   cfg_data;
	logic              done;
	logic              hit;
	logic [WAY_W-1:0]  way_used;
	logic [CNT_W-1:0]  hit_total;

	lru_tag_tracker board;

	// per-phase address pools: a few sets and a handful more tags than ways,
	// so the random part mixes hits, fills of empty ways and LRU evictions
	logic [ADDR_W-1:0] tag_pool [32];
	logic [ADDR_W-1:0] set_pool [4];
	int                pool_n;
	int                phases_run;

	set_assoc_cache_lru_tags dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.address  (address),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.done     (done),
		.hit      (hit),
		.way_used (way_used),
		.hit_total(hit_total)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sample at the rising edge: register writes, accepted accesses and
	// result strobes, in that order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) board.configure(cfg_data);
			if (start && !busy) board.note_access(address);
			if (done) board.check_result(hit, way_used, hit_total);
		end
	end

	// Hold start and the address from a falling edge until the item is taken;
	// then, with the given odds, drop start so that the gap lands on either
	// cycle of the block's lookup/write-back pair.
	task automatic send_access(input logic [ADDR_W-1:0] a, input int idle_pct);
		start <= 1'b1;
		address <= a;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			address <= $urandom();
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
	endtask

	// Wait until every result is back, then let the pipeline drain.
	task automatic settle();
		while (board.outstanding() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_ways(input logic [LG_W-1:0] lg);
		cfg_valid <= 1'b1;
		cfg_data <= lg;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [ADDR_W-1:0] pick_address();
		int sb;
		logic [ADDR_W-1:0] set_no;
		sb = board.set_bits();
		// some fully random noise, mostly pool traffic with random byte offsets
		if ($urandom_range(99) < 15) return $urandom();
		set_no = set_pool[$urandom_range(3)] & ((1 << sb) - 1);
		return (tag_pool[$urandom_range(pool_n - 1)] << (OFFSET_W + sb))
			| (set_no << OFFSET_W) | $urandom_range(31);
	endfunction

	// Change the way count with the block idle, draw fresh pools, then
	// stream accesses and drain.
	task automatic run_phase(input logic [LG_W-1:0] lg, input int idle_pct, input int count);
		int ways;
		write_ways(lg);
		ways = board.way_total();
		pool_n = ways + ways / 2 + 1;
		foreach (tag_pool[i]) tag_pool[i] = $urandom();
		foreach (set_pool[i]) set_pool[i] = $urandom();
		repeat (count) send_access(pick_address(), idle_pct);
		start <= 1'b0;
		settle();
		phases_run++;
	endtask

	initial begin
		int guard;
		board = new();
		phases_run = 0;
		arst_n = 1'b0;
		start = 1'b0;
		address = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset organization, 2 ways, tag from bit 13 up, set in 12:5.
		send_access(32'h0000_0000, 0);  // empty set 0: fill way 0
		send_access(32'hFFFF_FFFF, 0);  // all ones: last set, largest tag
		send_access(32'hFFFF_FFE0, 0);  // same line, other offset: hit
		send_access(32'h0000_001F, 0);  // hit way 0 of set 0
		send_access(32'h0000_2000, 0);  // second tag fills way 1
		send_access(32'h0000_0000, 0);  // hit refreshes way 0
		send_access(32'h0000_4000, 0);  // set full: evict way 1, the oldest
		send_access(32'h0000_2000, 0);  // now way 0 is oldest
		send_access(32'h0000_4000, 0);  // hit way 1
		send_access(32'hAAAA_AAAA, 0);
		send_access(32'h5555_5555, 0);
		send_access(32'h8000_0000, 0);  // top bit only, set 0 again
		send_access(32'h0000_0000, 0);
		send_access(32'h0000_2000, 0);
		start <= 1'b0;
		settle();

		// Random phases over every way count, clamped settings included; the
		// idle setting varies by phase among none, light and heavy.
		run_phase(3'd4, 0, 200);
		run_phase(3'd1, 67, 200);
		run_phase(3'd0, 0, 200);
		run_phase(3'd2, 20, 200);
		run_phase(3'd7, 0, 200);
		run_phase(3'd3, 67, 200);
		run_phase(3'd5, 0, 200);
		run_phase(3'd6, 20, 200);
		run_phase(3'd4, 67, 200);
		run_phase(3'd1, 0, 200);

		guard = 0;
		while (board.outstanding() != 0 && guard < 1000) begin
			@(negedge clk);
			guard++;
		end
		repeat (5) @(negedge clk);
		if (board.outstanding() != 0)
			board.flag($sformatf("%0d results never arrived", board.outstanding()));

		$display("covered %0d accesses (%0d hits) over %0d way-count phases",
			board.compared, board.hits_seen, phases_run);
		$display("mismatches: %0d", board.errors);
		if (board.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Hang guard, far beyond the slowest legal run.
	initial begin
		#5000000;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
